/* design/cbpm_pkg.sv */
// shared types, codes and count-pair helpers for the count probability model
// no dependencies
`default_nettype none

package cbpm_pkg;

  // request modes
  localparam logic [1:0] MODE_PREDICT = 2'd0;
  localparam logic [1:0] MODE_UPDATE  = 2'd1;
  localparam logic [1:0] MODE_CLEAR   = 2'd2;

  // prior settings
  localparam logic [1:0] PRIOR_WEAK = 2'd1;
  localparam logic [1:0] PRIOR_MID  = 2'd2;

  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
  localparam logic [16:0] BACKOFF_K    = 17'd8;
  localparam logic [16:0] PROB_MAX     = 17'd65534;

  typedef struct packed {
    logic [15:0] no;
    logic [15:0] yes;
  } pair_t;

  typedef struct packed {
    pair_t f;
    pair_t l;
    pair_t c;
    pair_t b;
    pair_t s;
  } pairs_t;

  typedef struct packed {
    logic rd;
    logic wr;
    logic sweep;
  } tbl_ctrl_t;

  // total of a pair, never zero
  function automatic logic [16:0] pair_total(input pair_t p);
    logic [16:0] t;
    t = {1'b0, p.no} + {1'b0, p.yes};
    return (t == 17'd0) ? 17'd1 : t;
  endfunction

  // saturating increment, then halve with rounding once over the limit
  function automatic pair_t bump(input pair_t p, input logic take, input logic [16:0] limit);
    pair_t       q;
    logic [16:0] sum;
    logic [16:0] hn;
    logic [16:0] hy;
    q = p;
    if (take) begin
      if (p.yes != COUNT_MAX) q.yes = p.yes + 16'd1;
    end else if (p.no != COUNT_MAX) begin
      q.no = p.no + 16'd1;
    end
    sum = {1'b0, q.no} + {1'b0, q.yes};
    if (sum > limit) begin
      hn = ({1'b0, q.no} + 17'd1) >> 1;
      hy = ({1'b0, q.yes} + 17'd1) >> 1;
      q.no  = (hn[15:0] == 16'd0) ? 16'd1 : hn[15:0];
      q.yes = (hy[15:0] == 16'd0) ? 16'd1 : hy[15:0];
    end
    return q;
  endfunction

endpackage

`default_nettype wire

/* design/cbpm_if.sv */
// request and result channel interfaces
// depends on nothing
`default_nettype none

interface cbpm_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] pattern_code;
  logic [8:0] full_context;
  logic [8:0] class_ctx;
  logic [5:0] secondary_ctx;
  logic       outcome;

  modport source (output valid, mode, pattern_code, full_context, class_ctx,
                  secondary_ctx, outcome, input ready);
  modport sink   (input valid, mode, pattern_code, full_context, class_ctx,
                  secondary_ctx, outcome, output ready);
endinterface

interface cbpm_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] probability;

  modport source (output valid, probability, input ready);
  modport sink   (input valid, probability, output ready);
endinterface

`default_nettype wire

/* design/backoff_count_probability_model.sv */
// top level: sequencer around the count memories and the shared divider
// depends on cbpm_pkg, cbpm_if, cbpm_tables, cbpm_divider
//
// Usage: requests arrive on req (mode, pattern_code, contexts, outcome) and
// every request gives exactly one result on rsp (probability, zero unless
// predict). cfg_we/cfg_data set the prior used by a clear.
// One request is worked at a time; req.ready is high only when idle.
// Predict: five divisions done in turn on the one shared divider (ratio
// and backed-off ratio for fine and class, then secondary), after the read
// and load and before the output.
// Update: one read then one write-back of all five memories.
// Clear: a fill pass over the memories, one entry per cycle, across the
// depth of the fine and class memories.
// Out-of-range patterns and the unused mode answer zero.
// Reset: the same fill pass (no 1, yes 1) runs with req.ready low;
// configuration writes are taken during it.
// Stall: the result sits in an output register; a request can be accepted
// while it waits, and a later result waits until the register is free.
`default_nettype none

module backoff_count_probability_model
  import cbpm_pkg::*;
#(
  parameter int NUM_PATTERNS = 128,
  parameter int HALVE_LIMIT  = 4096
) (
  input  wire logic       clk,
  input  wire logic       rst,
  cbpm_req_if.sink        req,
  cbpm_rsp_if.source      rsp,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_data
);

  localparam int FINE_DEPTH = NUM_PATTERNS * 512;
  localparam int FINE_AW    = $clog2(FINE_DEPTH);
  localparam logic [16:0] LIMIT    = 17'(HALVE_LIMIT);
  localparam logic [7:0]  CODE_MAX = 8'(NUM_PATTERNS);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SWEEP = 6'b000010,
    S_READ  = 6'b000100,
    S_LOAD  = 6'b001000,
    S_DIV   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state;

  logic [1:0]         prior;
  logic [15:0]        fill_yes;
  logic               sweep_reply;
  logic [FINE_AW-1:0] sweep_cnt;

  logic [7:0] row;
  logic [8:0] fctx;
  logic [8:0] cctx;
  logic [5:0] sctx;
  logic       take;
  logic       is_pred;

  logic [2:0]  step;
  logic        launch;
  logic [16:0] r_l, r_f, r_b, r_c, r_s;

  tbl_ctrl_t ctrl;
  pairs_t    rdata;
  pairs_t    wdata;

  logic        div_start, div_busy, div_done;
  logic [32:0] div_num;
  logic [17:0] div_den;
  logic [16:0] div_q;

  logic        bad_code;
  logic [17:0] sum_fc;
  logic [16:0] structural;
  logic [18:0] mix;
  logic [16:0] prob_raw;
  logic [15:0] prob_clamped;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      prior <= 2'd0;
    end else if (cfg_we) begin
      prior <= cfg_data;
    end
  end

  assign req.ready = (state == S_IDLE);
  assign bad_code  = (req.pattern_code == 8'd0) || (req.pattern_code > CODE_MAX);

  // memory controls and write data
  always_comb begin
    ctrl.rd    = (state == S_READ);
    ctrl.wr    = (state == S_SWEEP) || ((state == S_LOAD) && !is_pred);
    ctrl.sweep = (state == S_SWEEP);
    if (state == S_SWEEP) begin
      wdata.f = '{no: 16'd1, yes: fill_yes};
      wdata.l = wdata.f;
      wdata.c = wdata.f;
      wdata.b = wdata.f;
      wdata.s = wdata.f;
    end else begin
      wdata.f = bump(rdata.f, take, LIMIT);
      wdata.l = bump(rdata.l, take, LIMIT);
      wdata.c = bump(rdata.c, take, LIMIT);
      wdata.b = bump(rdata.b, take, LIMIT);
      wdata.s = bump(rdata.s, take, LIMIT);
    end
  end

  cbpm_tables #(.NUM_PATTERNS(NUM_PATTERNS)) u_tables (
    .clk        (clk),
    .ctrl       (ctrl),
    .sweep_addr (sweep_cnt),
    .row        (row),
    .fctx       (fctx),
    .cctx       (cctx),
    .sctx       (sctx),
    .wdata      (wdata),
    .rdata      (rdata)
  );

  // divider operands for each step of a prediction
  always_comb begin
    case (step)
      3'd0: begin
        div_num = {1'b0, rdata.l.yes, 16'd0};
        div_den = {1'b0, pair_total(rdata.l)};
      end
      3'd1: begin
        div_num = {1'b0, rdata.f.yes, 16'd0} + {13'd0, r_l, 3'd0};
        div_den = {1'b0, pair_total(rdata.f)} + {1'b0, BACKOFF_K};
      end
      3'd2: begin
        div_num = {1'b0, rdata.b.yes, 16'd0};
        div_den = {1'b0, pair_total(rdata.b)};
      end
      3'd3: begin
        div_num = {1'b0, rdata.c.yes, 16'd0} + {13'd0, r_b, 3'd0};
        div_den = {1'b0, pair_total(rdata.c)} + {1'b0, BACKOFF_K};
      end
      default: begin
        div_num = {1'b0, rdata.s.yes, 16'd0};
        div_den = {1'b0, pair_total(rdata.s)};
      end
    endcase
  end

  assign div_start = (state == S_DIV) && launch && !div_busy;

  cbpm_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_q)
  );

  // final mix and clamp
  always_comb begin
    sum_fc     = {1'b0, r_f} + {1'b0, r_c};
    structural = sum_fc[17:1];
    mix        = {2'b00, structural} + {1'b0, structural, 1'b0} + {2'b00, r_s};
    prob_raw   = mix[18:2];
    if (prob_raw < 17'd1) begin
      prob_clamped = 16'd1;
    end else if (prob_raw > PROB_MAX) begin
      prob_clamped = PROB_MAX[15:0];
    end else begin
      prob_clamped = prob_raw[15:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_SWEEP;
      sweep_cnt   <= '0;
      fill_yes    <= 16'd1;
      sweep_reply <= 1'b0;
      launch      <= 1'b0;
      step        <= 3'd0;
      is_pred     <= 1'b0;
      rsp.valid   <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            row     <= req.pattern_code - 8'd1;
            fctx    <= req.full_context;
            cctx    <= req.class_ctx;
            sctx    <= req.secondary_ctx;
            take    <= req.outcome;
            is_pred <= 1'b0;
            if (req.mode == MODE_CLEAR) begin
              sweep_cnt   <= '0;
              sweep_reply <= 1'b1;
              case (prior)
                PRIOR_WEAK: fill_yes <= 16'd3;
                PRIOR_MID:  fill_yes <= 16'd7;
                default:    fill_yes <= 16'd1;
              endcase
              state <= S_SWEEP;
            end else if (bad_code ||
                         (req.mode != MODE_PREDICT && req.mode != MODE_UPDATE)) begin
              state <= S_OUT;
            end else begin
              is_pred <= (req.mode == MODE_PREDICT);
              state   <= S_READ;
            end
          end
        end
        S_SWEEP: begin
          sweep_cnt <= sweep_cnt + FINE_AW'(1);
          if (sweep_cnt == FINE_AW'(FINE_DEPTH - 1)) begin
            state <= sweep_reply ? S_OUT : S_IDLE;
          end
        end
        S_READ: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (is_pred) begin
            step   <= 3'd0;
            launch <= 1'b1;
            state  <= S_DIV;
          end else begin
            state <= S_OUT;
          end
        end
        S_DIV: begin
          if (div_start) launch <= 1'b0;
          if (div_done) begin
            case (step)
              3'd0:    r_l <= div_q;
              3'd1:    r_f <= div_q;
              3'd2:    r_b <= div_q;
              3'd3:    r_c <= div_q;
              default: r_s <= div_q;
            endcase
            if (step == 3'd4) begin
              state <= S_OUT;
            end else begin
              step   <= step + 3'd1;
              launch <= 1'b1;
            end
          end
        end
        S_OUT: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid       <= 1'b1;
            rsp.probability <= is_pred ? prob_clamped : 16'd0;
            sweep_reply     <= 1'b0;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/cbpm_divider.sv */
// shared restoring divider, one quotient bit per cycle, 17-bit quotient
// depends on nothing; caller guarantees quotient below 2^17
`default_nettype none

module cbpm_divider (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [32:0] num,
  input  wire logic [17:0] den,
  output logic             busy,
  output logic             done,
  output logic [16:0]      quot
);

  logic [17:0] rem;
  logic [17:0] dv;
  logic [4:0]  cnt;
  logic [18:0] trial;
  logic [18:0] shifted;

  // one trial subtract per cycle
  assign shifted = {rem, quot[16]};
  assign trial   = shifted - {1'b0, dv};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 5'd0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 5'd17;
      rem  <= {2'b00, num[32:17]};
      quot <= num[16:0];
      dv   <= den;
    end else if (busy) begin
      if (!trial[18]) begin
        rem <= trial[17:0];
      end else begin
        rem <= shifted[17:0];
      end
      quot <= {quot[15:0], ~trial[18]};
      cnt  <= cnt - 5'd1;
      if (cnt == 5'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* design/cbpm_tables.sv */
// the five count-pair memories, one read or write per cycle each
// depends on cbpm_pkg
`default_nettype none

module cbpm_tables
  import cbpm_pkg::*;
#(
  parameter int NUM_PATTERNS = 128,
  localparam int FINE_DEPTH = NUM_PATTERNS * 512,
  localparam int LINE_DEPTH = NUM_PATTERNS * 8,
  localparam int SEC_DEPTH  = NUM_PATTERNS * 64,
  localparam int FINE_AW    = $clog2(FINE_DEPTH),
  localparam int LINE_AW    = $clog2(LINE_DEPTH),
  localparam int SEC_AW     = $clog2(SEC_DEPTH)
) (
  input  wire logic               clk,
  input  wire tbl_ctrl_t          ctrl,
  input  wire logic [FINE_AW-1:0] sweep_addr,
  input  wire logic [7:0]         row,
  input  wire logic [8:0]         fctx,
  input  wire logic [8:0]         cctx,
  input  wire logic [5:0]         sctx,
  input  wire pairs_t             wdata,
  output pairs_t                  rdata
);

  pair_t fine_mem  [FINE_DEPTH];
  pair_t line_mem  [LINE_DEPTH];
  pair_t class_mem [FINE_DEPTH];
  pair_t bcls_mem  [LINE_DEPTH];
  pair_t sec_mem   [SEC_DEPTH];

  logic [FINE_AW-1:0] fa;
  logic [LINE_AW-1:0] la;
  logic [FINE_AW-1:0] ca;
  logic [LINE_AW-1:0] ba;
  logic [SEC_AW-1:0]  sa;

  // entry addresses, sweep address during a fill
  always_comb begin
    if (ctrl.sweep) begin
      fa = sweep_addr;
      la = LINE_AW'(sweep_addr);
      ca = sweep_addr;
      ba = LINE_AW'(sweep_addr);
      sa = SEC_AW'(sweep_addr);
    end else begin
      fa = FINE_AW'({row, fctx});
      la = LINE_AW'({row, fctx[2:0]});
      ca = FINE_AW'({row, cctx});
      ba = LINE_AW'({row, cctx[2:0]});
      sa = SEC_AW'({row, sctx});
    end
  end

  // synchronous memories, registered read
  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      fine_mem[fa]  <= wdata.f;
      line_mem[la]  <= wdata.l;
      class_mem[ca] <= wdata.c;
      bcls_mem[ba]  <= wdata.b;
      sec_mem[sa]   <= wdata.s;
    end
    if (ctrl.rd) begin
      rdata.f <= fine_mem[fa];
      rdata.l <= line_mem[la];
      rdata.c <= class_mem[ca];
      rdata.b <= bcls_mem[ba];
      rdata.s <= sec_mem[sa];
    end
  end

endmodule

`default_nettype wire

/* design/cbpm_checker.sv */
// port-level checks for the count probability model, bound to the top level
// depends on nothing
`default_nettype none

module cbpm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [15:0] rsp_probability
);

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result shown after reset");

  // one request at a time: accepting drops ready
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("ready held after a request was taken");

  // probability never reaches full scale
  a_prob_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_probability != 16'hFFFF))
    else $error("probability out of range");

  // stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_probability)))
    else $error("stalled result changed");

endmodule

bind backoff_count_probability_model cbpm_checker u_cbpm_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_probability (rsp.probability)
);

`default_nettype wire

/* dv/backoff_count_probability_model_tb.sv */
// self-checking bench for backoff_count_probability_model: directed table, then random requests
// depends on cbpm_pkg, cbpm_if and the design top level
`timescale 1ns / 100ps

module backoff_count_probability_model_tb
  import cbpm_pkg::*;
();

  localparam logic [1:0] MODE_UNUSED  = 2'd3;
  localparam logic [1:0] PRIOR_NONE   = 2'd0;
  localparam logic [1:0] PRIOR_UNUSED = 2'd3;
  localparam int NO_CFG      = -1;
  localparam int LIMIT       = 3000000;
  localparam int PHASE_ITEMS = 275;
  localparam int TAB_FINE = 0, TAB_LINE = 1, TAB_CLASS = 2, TAB_BYTE = 3, TAB_SEC = 4;

  typedef struct {
    logic [1:0] mode;
    logic [7:0] code;
    logic [8:0] fctx;
    logic [8:0] cctx;
    logic [5:0] sctx;
    logic       outcome;
    bit         chk;
    logic [15:0] typed;
  } request_t;

  typedef struct {
    logic [15:0] prob;
    bit          chk;
    logic [15:0] typed;
  } prob_exp_t;

  typedef struct {
    int         cfg;
    logic [1:0] mode;
    logic [7:0] code;
    logic [8:0] fctx;
    logic [8:0] cctx;
    logic [5:0] sctx;
    logic       outcome;
    bit         chk;
    logic [15:0] typed;
  } dir_row_t;

  localparam int DIR_ROWS = 20;
  dir_row_t dir_tab [0:DIR_ROWS-1] = '{
    '{NO_CFG, MODE_PREDICT, 8'd1,   9'd0,   9'd0,   6'd0,  1'b0, 1, 16'd32768},
    '{NO_CFG, MODE_PREDICT, 8'd128, 9'd511, 9'd511, 6'd63, 1'b1, 1, 16'd32768},
    '{NO_CFG, MODE_PREDICT, 8'd0,   9'd5,   9'd5,   6'd5,  1'b0, 1, 16'd0},
    '{NO_CFG, MODE_PREDICT, 8'd129, 9'd5,   9'd5,   6'd5,  1'b0, 1, 16'd0},
    '{NO_CFG, MODE_UPDATE,  8'd255, 9'd3,   9'd3,   6'd3,  1'b1, 1, 16'd0},
    '{NO_CFG, MODE_UNUSED,  8'd1,   9'd3,   9'd3,   6'd3,  1'b1, 1, 16'd0},
    '{NO_CFG, MODE_UPDATE,  8'd1,   9'd3,   9'd3,   6'd3,  1'b1, 1, 16'd0},
    '{NO_CFG, MODE_PREDICT, 8'd1,   9'd3,   9'd3,   6'd3,  1'b0, 0, 16'd0},
    '{NO_CFG, MODE_UPDATE,  8'd128, 9'd511, 9'd511, 6'd63, 1'b0, 1, 16'd0},
    '{NO_CFG, MODE_UPDATE,  8'd128, 9'd511, 9'd511, 6'd63, 1'b0, 1, 16'd0},
    '{NO_CFG, MODE_PREDICT, 8'd128, 9'd511, 9'd511, 6'd63, 1'b0, 0, 16'd0},
    '{NO_CFG, MODE_PREDICT, 8'd128, 9'd7,   9'd7,   6'd63, 1'b0, 0, 16'd0},
    '{NO_CFG, MODE_CLEAR,   8'd0,   9'd0,   9'd0,   6'd0,  1'b0, 1, 16'd0},
    '{NO_CFG, MODE_PREDICT, 8'd128, 9'd511, 9'd511, 6'd63, 1'b0, 1, 16'd32768},
    '{PRIOR_MID, MODE_CLEAR, 8'd1,  9'd0,   9'd0,   6'd0,  1'b1, 1, 16'd0},
    '{NO_CFG, MODE_PREDICT, 8'd64,  9'd100, 9'd200, 6'd30, 1'b0, 1, 16'd57344},
    '{NO_CFG, MODE_UPDATE,  8'd64,  9'd100, 9'd200, 6'd30, 1'b0, 1, 16'd0},
    '{NO_CFG, MODE_PREDICT, 8'd64,  9'd100, 9'd200, 6'd30, 1'b0, 0, 16'd0},
    '{PRIOR_UNUSED, MODE_CLEAR, 8'd2, 9'd0, 9'd0,   6'd0,  1'b0, 1, 16'd0},
    '{NO_CFG, MODE_PREDICT, 8'd64,  9'd100, 9'd200, 6'd30, 1'b0, 1, 16'd32768}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_data = 2'd0;

  cbpm_req_if req ();
  cbpm_rsp_if rsp ();

  backoff_count_probability_model DUT (
    .clk      (clk),
    .rst      (rst),
    .req      (req.sink),
    .rsp      (rsp.source),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  request_t  stim_q[$];
  prob_exp_t prob_q[$];
  bit        sending = 0;
  bit        hold_pending = 0;
  int        err_cnt = 0;
  int        sent_cnt = 0;
  int        got_cnt = 0;
  int        predict_cnt = 0;
  int        clear_cnt = 0;
  int        cycles = 0;

  bit          req_chk_next = 0;
  logic [15:0] req_typed_next = 16'd0;

  // model of the count tables: entries never touched since the last clear read as fill_pair
  pair_t      cnt_mem[int];
  pair_t      fill_pair = '{no: 16'd1, yes: 16'd1};
  logic [1:0] prior_cur = PRIOR_NONE;

  function automatic pair_t read_pair(int key);
    return cnt_mem.exists(key) ? cnt_mem[key] : fill_pair;
  endfunction

  function automatic longint unsigned count_sum(pair_t p);
    longint unsigned t;
    t = longint'(p.no) + longint'(p.yes);
    return (t == 0) ? 1 : t;
  endfunction

  function automatic longint unsigned yes_ratio(pair_t p);
    return (longint'(p.yes) * 65536) / count_sum(p);
  endfunction

  function automatic longint unsigned backoff_ratio(pair_t fp, longint unsigned coarse);
    return (longint'(fp.yes) * 65536 + 8 * coarse) / (count_sum(fp) + 8);
  endfunction

  // saturating count then halving once the pair total passes the limit
  function automatic void count_outcome(int key, logic take);
    pair_t p;
    int    n, y;
    p = read_pair(key);
    n = p.no;
    y = p.yes;
    if (take) begin
      if (y != 65535) y++;
    end else if (n != 65535) begin
      n++;
    end
    if (n + y > 4096) begin
      n = (n + 1) >> 1;
      y = (y + 1) >> 1;
      if (n == 0) n = 1;
      if (y == 0) y = 1;
    end
    p.no = n[15:0];
    p.yes = y[15:0];
    cnt_mem[key] = p;
  endfunction

  function automatic logic [15:0] predict_probability(request_t r);
    int key [5];
    int row;
    longint unsigned structural, p;
    if (r.mode == MODE_CLEAR) begin
      cnt_mem.delete();
      fill_pair.no = 16'd1;
      fill_pair.yes = (prior_cur == PRIOR_WEAK) ? 16'd3 :
                      (prior_cur == PRIOR_MID) ? 16'd7 : 16'd1;
      return 16'd0;
    end
    if (r.mode == MODE_UNUSED || r.code == 0 || r.code > 128) return 16'd0;
    row = r.code - 1;
    key[0] = TAB_FINE * 65536 + row * 512 + r.fctx;
    key[1] = TAB_LINE * 65536 + row * 8 + r.fctx[2:0];
    key[2] = TAB_CLASS * 65536 + row * 512 + r.cctx;
    key[3] = TAB_BYTE * 65536 + row * 8 + r.cctx[2:0];
    key[4] = TAB_SEC * 65536 + row * 64 + r.sctx;
    if (r.mode == MODE_PREDICT) begin
      structural = (backoff_ratio(read_pair(key[0]), yes_ratio(read_pair(key[1])))
                  + backoff_ratio(read_pair(key[2]), yes_ratio(read_pair(key[3])))) >> 1;
      p = (3 * structural + yes_ratio(read_pair(key[4]))) >> 2;
      if (p < 1) p = 1;
      if (p > 65534) p = 65534;
      return p[15:0];
    end
    foreach (key[i]) count_outcome(key[i], r.outcome);
    return 16'd0;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] want, logic [15:0] got);
    $display("mismatch %s: result %0d expected %0d got %0d at %0t",
             what, got_cnt, want, got, $realtime);
    err_cnt++;
  endtask

  // random request: mostly a few hot patterns and contexts so counts build up
  function automatic request_t random_request(bit allow_clear);
    request_t r;
    int pick;
    pick = $urandom_range(0, 99);
    r.mode = (pick < 46) ? MODE_UPDATE : (pick < 94) ? MODE_PREDICT :
             (pick < 97) ? MODE_UNUSED : MODE_UPDATE;
    if (allow_clear) r.mode = MODE_CLEAR;
    pick = $urandom_range(0, 99);
    if (pick < 70) r.code = 8'($urandom_range(1, 3));
    else if (pick < 92) r.code = 8'($urandom_range(1, 128));
    else if (pick < 95) r.code = 8'd0;
    else r.code = 8'($urandom_range(129, 255));
    if ($urandom_range(0, 1)) begin
      r.fctx = 9'($urandom_range(0, 3));
      r.cctx = 9'd508 + 9'($urandom_range(0, 3));
      r.sctx = 6'($urandom_range(0, 2));
    end else begin
      r.fctx = 9'($urandom);
      r.cctx = 9'($urandom);
      r.sctx = 6'($urandom);
    end
    r.outcome = ($urandom_range(0, 3) != 0);
    r.chk = 0;
    r.typed = 16'd0;
    return r;
  endfunction

  // request sender, gap drawn per request, calm stretches with no gaps
  initial begin
    request_t r;
    int gap;
    req.mode <= MODE_PREDICT;
    req.pattern_code <= 8'd0;
    req.full_context <= 9'd0;
    req.class_ctx <= 9'd0;
    req.secondary_ctx <= 6'd0;
    req.outcome <= 1'b0;
    forever begin
      if (stim_q.size() == 0) begin
        req.valid <= 1'b0;
        @(posedge clk);
      end else begin
        r = stim_q.pop_front();
        sending = 1;
        gap = ((sent_cnt / 60) % 4 == 1) ? 0 : $urandom_range(0, 18);
        if (gap != 0) begin
          req.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.mode <= r.mode;
        req.pattern_code <= r.code;
        req.full_context <= r.fctx;
        req.class_ctx <= r.cctx;
        req.secondary_ctx <= r.sctx;
        req.outcome <= r.outcome;
        req_chk_next <= r.chk;
        req_typed_next <= r.typed;
        do @(posedge clk); while (!(req.valid && req.ready));
        sent_cnt++;
        sending = 0;
      end
    end
  end

  // predict at acceptance
  always @(posedge clk) begin
    request_t r;
    prob_exp_t e;
    if (!rst && req.valid && req.ready) begin
      r.mode = req.mode;
      r.code = req.pattern_code;
      r.fctx = req.full_context;
      r.cctx = req.class_ctx;
      r.sctx = req.secondary_ctx;
      r.outcome = req.outcome;
      if (r.mode == MODE_PREDICT) predict_cnt++;
      if (r.mode == MODE_CLEAR) clear_cnt++;
      e.prob = predict_probability(r);
      e.chk = req_chk_next;
      e.typed = req_typed_next;
      prob_q.insert(prob_q.size(), e);
    end
  end

  // result receiver with per-result stalls and one long hold-off
  initial begin
    int st;
    forever begin
      st = ((got_cnt / 70) % 4 == 2) ? 0 : $urandom_range(0, 18);
      if (hold_pending) begin
        rsp.ready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_pending = 0;
      end else if (st != 0) begin
        rsp.ready <= 1'b0;
        repeat (st) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!(rsp.valid && rsp.ready));
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    prob_exp_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      if (prob_q.size() == 0) begin
        report_mismatch("unexpected result", 16'd0, rsp.probability);
      end else begin
        e = prob_q.pop_front();
        if (rsp.probability !== e.prob) report_mismatch("probability", e.prob, rsp.probability);
        if (e.chk && rsp.probability !== e.typed)
          report_mismatch("table value", e.typed, rsp.probability);
      end
      got_cnt++;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  task automatic wait_idle();
    while (stim_q.size() != 0 || sending || prob_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_prior(logic [1:0] v);
    wait_idle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    prior_cur = v;
  endtask

  // main sequence
  initial begin
    request_t r;
    logic [1:0] prior_seq [4];
    int clear_at;
    prior_seq = '{PRIOR_WEAK, PRIOR_NONE, PRIOR_UNUSED, PRIOR_MID};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    write_prior(PRIOR_NONE);

    // directed table
    foreach (dir_tab[i]) begin
      if (dir_tab[i].cfg != NO_CFG) write_prior(dir_tab[i].cfg[1:0]);
      r.mode = dir_tab[i].mode;
      r.code = dir_tab[i].code;
      r.fctx = dir_tab[i].fctx;
      r.cctx = dir_tab[i].cctx;
      r.sctx = dir_tab[i].sctx;
      r.outcome = dir_tab[i].outcome;
      r.chk = dir_tab[i].chk;
      r.typed = dir_tab[i].typed;
      stim_q.insert(stim_q.size(), r);
    end

    // random phases, each under its own prior with one clear inside
    foreach (prior_seq[p]) begin
      write_prior(prior_seq[p]);
      if (p == 0) hold_pending = 1;
      clear_at = $urandom_range(20, PHASE_ITEMS - 40);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        while (stim_q.size() > 8) @(posedge clk);
        stim_q.insert(stim_q.size(), random_request(k == clear_at));
      end
    end

    wait_idle();
    repeat (40) @(posedge clk);
    $display("covered %0d requests: %0d predicts, %0d clears, all four prior settings",
             sent_cnt, predict_cnt, clear_cnt);
    if (err_cnt == 0 && prob_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
